FILE: hdl/swrs_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window request statistics package
// Shared constants, bucket entry layout, controller states and the command
// and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package swrs_pkg;

  // Number of one-second buckets; a power of two, so the slot is the low bits.
  localparam int RING_SIZE = 1024;
  localparam int IDX_W     = $clog2(RING_SIZE);

  localparam int WIN_W   = 11;
  localparam int STAMP_W = 32;
  localparam int CNT_W   = 32;
  localparam int TOT_W   = 48;
  localparam int DUR_W   = 32;

  // Sums over the whole ring.
  localparam int REQ_SUM_W = CNT_W + IDX_W;
  localparam int TOT_SUM_W = TOT_W + IDX_W;
  localparam int BKT_CNT_W = IDX_W + 1;

  // Shared divider operands.
  localparam int NUM_W = TOT_SUM_W;
  localparam int DEN_W = REQ_SUM_W;
  localparam int DIV_CNT_W = $clog2(NUM_W + 1);

  localparam int AVG_W = 39;
  localparam int ERR_W = 14;
  localparam logic [ERR_W-1:0] ERR_FULL = ERR_W'(10000);

  localparam logic [WIN_W-1:0] RATE_WINDOW_RESET    = WIN_W'(600);
  localparam logic [WIN_W-1:0] LATENCY_WINDOW_RESET = WIN_W'(10);
  localparam logic [WIN_W-1:0] ERROR_WINDOW_RESET   = WIN_W'(60);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_WINDOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LATENCY_WINDOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_WINDOW   = 2'd2;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  localparam logic [1:0] DIV_AVG = 2'd0;
  localparam logic [1:0] DIV_LAT = 2'd1;
  localparam logic [1:0] DIV_ERR = 2'd2;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [CNT_W-1:0]   requests;
    logic [CNT_W-1:0]   errors;
    logic [TOT_W-1:0]   dur_total;
  } swrs_entry_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_REC_WR, ST_WALK, ST_DRAIN, ST_PREP,
    ST_DIV_START, ST_DIV_WAIT, ST_FINISH
  } swrs_state_t;

  typedef struct packed {
    logic             latch;
    logic             clr_wr;
    logic             in_rd;
    logic             walk_rd;
    logic             rec_wr;
    logic             acc_clr;
    logic             prep;
    logic             div_start;
    logic             div_cap;
    logic [1:0]       div_sel;
    logic             load_out;
    logic [IDX_W-1:0] addr;
  } swrs_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_valid;
  } swrs_status_t;

endpackage

FILE: hdl/sliding_window_request_stats.sv
// ----------------------------------------------------------------------------
// Sliding window request statistics
// Per-second bucket ring with record updates and windowed reports.
// ----------------------------------------------------------------------------
// The input stream carries one transaction per request or report. tuser is
// the opcode: a record transaction counts one request into the bucket of its
// second, a report transaction walks the whole ring and returns one result
// transaction on the output stream with current, average and peak rates,
// mean duration and error rate. Records produce no output.
// A record reads its bucket in the accept cycle and writes it back in the
// next; tready is low meanwhile, so the next record waits for the write.
// A report walks the whole ring, reading one bucket per cycle from the bucket
// memory; then one shared restoring divider computes the three quotients in
// turn, one bit per cycle, each with its own start and capture.
// After reset the block clears the bucket memory, one entry per cycle;
// input tready stays low during that pass, while the configuration port
// is taken at any time. The window registers take their reset values.
// A finished result waits in the output register while the receiver stalls;
// records keep flowing meanwhile, and only the next report's completion
// waits for the register to be taken.
// ----------------------------------------------------------------------------
module sliding_window_request_stats (
  input  logic         clk,
  input  logic         rst,
  // Configuration write port.
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [10:0]  cfg_wdata,
  // Input stream.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: timestamp_s[31:0], ok[32], duration_us[64:33], zero pad to 72.
  input  logic [71:0]  s_axis_tdata,
  // tuser: op[0].
  input  logic [0:0]   s_axis_tuser,
  // Output stream.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: rps_current[31:0], rps_avg_x100[70:32], rps_peak[102:71],
  // mean_dur_us[134:103], err_rate_x100[148:135], zero pad to 152.
  output logic [151:0] m_axis_tdata
);
  import swrs_pkg::*;

  swrs_cmd_t    cmd;
  swrs_status_t status;

  logic [CNT_W-1:0] rps_current, rps_peak, mean_dur_us;
  logic [AVG_W-1:0] rps_avg_x100;
  logic [ERR_W-1:0] err_rate_x100;

  swrs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_op     (s_axis_tuser[0]),
    .in_ready  (s_axis_tready),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  swrs_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_ts         (s_axis_tdata[31:0]),
    .in_ok         (s_axis_tdata[32]),
    .in_dur        (s_axis_tdata[64:33]),
    .out_ready     (m_axis_tready),
    .out_valid     (m_axis_tvalid),
    .rps_current   (rps_current),
    .rps_avg_x100  (rps_avg_x100),
    .rps_peak      (rps_peak),
    .mean_dur_us   (mean_dur_us),
    .err_rate_x100 (err_rate_x100)
  );

  assign m_axis_tdata = {3'b000, err_rate_x100, mean_dur_us, rps_peak,
                         rps_avg_x100, rps_current};

endmodule

FILE: hdl/swrs_div.sv
// ----------------------------------------------------------------------------
// Sliding window request statistics divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module swrs_div (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [swrs_pkg::NUM_W-1:0] num,
  input  logic [swrs_pkg::DEN_W-1:0] den,
  output logic                  done,
  output logic [swrs_pkg::NUM_W-1:0] quot
);
  import swrs_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DEN_W:0]       rem;
  logic [NUM_W-1:0]     shreg;
  logic [DEN_W-1:0]     dreg;
  logic [DEN_W:0]       trial;
  logic [DEN_W+1:0]     diff;

  assign trial = {rem[DEN_W-1:0], shreg[NUM_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dreg};
  assign quot  = shreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      shreg <= num;
      dreg  <= den;
    end else if (busy) begin
      if (!diff[DEN_W+1]) begin
        rem <= diff[DEN_W:0];
      end else begin
        rem <= trial;
      end
      shreg <= {shreg[NUM_W-2:0], ~diff[DEN_W+1]};
    end
  end

endmodule

FILE: hdl/swrs_ctrl.sv
// ----------------------------------------------------------------------------
// Sliding window request statistics controller
// Sequences ring clearing, record updates, report walks and divisions.
// ----------------------------------------------------------------------------
module swrs_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_op,
  output logic                   in_ready,
  input  logic                   out_ready,
  input  swrs_pkg::swrs_status_t status,
  output swrs_pkg::swrs_cmd_t    cmd
);
  import swrs_pkg::*;

  swrs_state_t      state, state_next;
  logic [IDX_W-1:0] ctr, ctr_next;
  logic [1:0]       sel, sel_next;
  logic             ctr_last;

  assign ctr_last = (ctr == IDX_W'(RING_SIZE - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      ctr   <= '0;
      sel   <= DIV_AVG;
    end else begin
      state <= state_next;
      ctr   <= ctr_next;
      sel   <= sel_next;
    end
  end

  always_comb begin
    state_next = state;
    ctr_next   = ctr;
    sel_next   = sel;
    case (state)
      ST_CLEAR: begin
        ctr_next = ctr + 1'b1;
        if (ctr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          ctr_next   = '0;
          state_next = (in_op == OP_RECORD) ? ST_REC_WR : ST_WALK;
        end
      end
      ST_REC_WR: state_next = ST_IDLE;
      ST_WALK: begin
        ctr_next = ctr + 1'b1;
        if (ctr_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_PREP;
      ST_PREP: begin
        sel_next   = DIV_AVG;
        state_next = ST_DIV_START;
      end
      ST_DIV_START: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (status.div_done) begin
          if (sel == DIV_ERR) begin
            state_next = ST_FINISH;
          end else begin
            sel_next   = sel + 1'b1;
            state_next = ST_DIV_START;
          end
        end
      end
      ST_FINISH: begin
        if (!status.out_valid || out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.addr = ctr;
    cmd.div_sel = sel;
    in_ready = 1'b0;
    case (state)
      ST_CLEAR: cmd.clr_wr = 1'b1;
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
        cmd.in_rd = in_valid && (in_op == OP_RECORD);
        cmd.acc_clr = in_valid && (in_op == OP_REPORT);
      end
      ST_REC_WR:    cmd.rec_wr = 1'b1;
      ST_WALK:      cmd.walk_rd = 1'b1;
      ST_PREP:      cmd.prep = 1'b1;
      ST_DIV_START: cmd.div_start = 1'b1;
      ST_DIV_WAIT:  cmd.div_cap = status.div_done;
      ST_FINISH:    cmd.load_out = !status.out_valid || out_ready;
      default: ;
    endcase
  end

endmodule

FILE: hdl/swrs_dp.sv
// ----------------------------------------------------------------------------
// Sliding window request statistics datapath
// Bucket memory, record update, report accumulators and result register.
// ----------------------------------------------------------------------------
module swrs_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  swrs_pkg::swrs_cmd_t           cmd,
  output swrs_pkg::swrs_status_t        status,
  input  logic                          cfg_we,
  input  logic [swrs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [swrs_pkg::WIN_W-1:0]    cfg_wdata,
  input  logic [swrs_pkg::STAMP_W-1:0]  in_ts,
  input  logic                          in_ok,
  input  logic [swrs_pkg::DUR_W-1:0]    in_dur,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [swrs_pkg::CNT_W-1:0]    rps_current,
  output logic [swrs_pkg::AVG_W-1:0]    rps_avg_x100,
  output logic [swrs_pkg::CNT_W-1:0]    rps_peak,
  output logic [swrs_pkg::CNT_W-1:0]    mean_dur_us,
  output logic [swrs_pkg::ERR_W-1:0]    err_rate_x100
);
  import swrs_pkg::*;

  logic [WIN_W-1:0] rate_win, lat_win, err_win;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_win <= RATE_WINDOW_RESET;
      lat_win  <= LATENCY_WINDOW_RESET;
      err_win  <= ERROR_WINDOW_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RATE_WINDOW:    rate_win <= cfg_wdata;
        REG_LATENCY_WINDOW: lat_win  <= cfg_wdata;
        REG_ERROR_WINDOW:   err_win  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Latched input item.
  logic [STAMP_W-1:0] now;
  logic               ok_q;
  logic [DUR_W-1:0]   dur_q;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      now   <= in_ts;
      ok_q  <= in_ok;
      dur_q <= in_dur;
    end
  end

  // Bucket memory with registered read.
  swrs_entry_t      mem [RING_SIZE];
  swrs_entry_t      rdata, wdata, upd, base;
  logic [IDX_W-1:0] raddr, waddr;
  logic             rd_en, we;
  logic [TOT_W:0]   tot_sum;

  assign raddr = cmd.in_rd ? in_ts[IDX_W-1:0] : cmd.addr;
  assign rd_en = cmd.in_rd || cmd.walk_rd;
  assign waddr = cmd.rec_wr ? now[IDX_W-1:0] : cmd.addr;
  assign we    = cmd.rec_wr || cmd.clr_wr;
  assign wdata = cmd.clr_wr ? '0 : upd;

  always_ff @(posedge clk) begin
    if (rd_en) rdata <= mem[raddr];
    if (we) mem[waddr] <= wdata;
  end

  // A bucket holding another second starts over.
  always_comb begin
    base = rdata;
    if (rdata.stamp != now) base = '0;
    upd = base;
    upd.stamp = now;
    if (base.requests != '1) upd.requests = base.requests + 1'b1;
    if (!ok_q && base.errors != '1) upd.errors = base.errors + 1'b1;
    tot_sum = {1'b0, base.dur_total} + {(TOT_W + 1 - DUR_W)'(0), dur_q};
    upd.dur_total = tot_sum[TOT_W] ? '1 : tot_sum[TOT_W-1:0];
  end

  // Report walk accumulators, fed in the cycle after each read.
  logic                 rd_d;
  logic [STAMP_W-1:0]   age;
  logic                 live;
  logic [CNT_W-1:0]     cur;
  logic [CNT_W-1:0]     peak;
  logic [REQ_SUM_W-1:0] rate_sum, lat_reqs, err_errs, err_reqs;
  logic [BKT_CNT_W-1:0] rate_cnt;
  logic [TOT_SUM_W-1:0] lat_sum;

  assign age  = now - rdata.stamp;
  assign live = rd_d && (rdata.stamp != '0) && (rdata.stamp <= now)
                && (age <= STAMP_W'(RING_SIZE));

  always_ff @(posedge clk) begin
    if (rst) rd_d <= 1'b0;
    else     rd_d <= cmd.walk_rd;
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      cur      <= '0;
      peak     <= '0;
      rate_sum <= '0;
      rate_cnt <= '0;
      lat_sum  <= '0;
      lat_reqs <= '0;
      err_errs <= '0;
      err_reqs <= '0;
    end else if (live) begin
      if (age == STAMP_W'(1)) cur <= rdata.requests;
      if (age <= {(STAMP_W - WIN_W)'(0), rate_win}) begin
        rate_sum <= rate_sum + REQ_SUM_W'(rdata.requests);
        rate_cnt <= rate_cnt + 1'b1;
        if (rdata.requests > peak) peak <= rdata.requests;
      end
      if (age <= {(STAMP_W - WIN_W)'(0), lat_win}) begin
        lat_sum  <= lat_sum + TOT_SUM_W'(rdata.dur_total);
        lat_reqs <= lat_reqs + REQ_SUM_W'(rdata.requests);
      end
      if (age <= {(STAMP_W - WIN_W)'(0), err_win}) begin
        err_errs <= err_errs + REQ_SUM_W'(rdata.errors);
        err_reqs <= err_reqs + REQ_SUM_W'(rdata.requests);
      end
    end
  end

  // Scaled numerators: x100 and x10000 as shift-and-add.
  logic [NUM_W-1:0] avg_num, err_num;
  logic [NUM_W-1:0] rs, ee;

  assign rs = NUM_W'(rate_sum);
  assign ee = NUM_W'(err_errs);

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      avg_num <= (rs << 6) + (rs << 5) + (rs << 2);
      err_num <= (ee << 13) + (ee << 10) + (ee << 9) + (ee << 8) + (ee << 4);
    end
  end

  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic [NUM_W-1:0] quot;
  logic             div_done;

  always_comb begin
    case (cmd.div_sel)
      DIV_AVG: begin
        div_num = avg_num;
        div_den = DEN_W'(rate_cnt);
      end
      DIV_LAT: begin
        div_num = lat_sum;
        div_den = lat_reqs;
      end
      default: begin
        div_num = err_num;
        div_den = err_reqs;
      end
    endcase
  end

  swrs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (quot)
  );

  logic [AVG_W-1:0] avg_q;
  logic [CNT_W-1:0] tm_q;
  logic [ERR_W-1:0] er_q;
  logic             den_zero;

  assign den_zero = (div_den == '0);

  always_ff @(posedge clk) begin
    if (cmd.div_cap) begin
      case (cmd.div_sel)
        DIV_AVG: avg_q <= den_zero ? '0 : quot[AVG_W-1:0];
        DIV_LAT: begin
          if (den_zero)                  tm_q <= '0;
          else if (quot[NUM_W-1:CNT_W] != '0) tm_q <= '1;
          else                           tm_q <= quot[CNT_W-1:0];
        end
        default: begin
          if (den_zero)                            er_q <= '0;
          else if (quot > NUM_W'(ERR_FULL))        er_q <= ERR_FULL;
          else                                     er_q <= quot[ERR_W-1:0];
        end
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rps_current   <= cur;
      rps_avg_x100  <= avg_q;
      rps_peak      <= peak;
      mean_dur_us   <= tm_q;
      err_rate_x100 <= er_q;
    end
  end

  assign status.div_done  = div_done;
  assign status.out_valid = out_valid;

endmodule
